>>> hw/rtl/isss_pkg.sv
package isss_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int TYPE_W = 2;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SORT  = 2'd2;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
  } store_cmd_t;

endpackage

>>> hw/rtl/isss_if.sv
interface isss_req_if
  import isss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [TYPE_W-1:0]        req_type;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, index, value, input ready);
  modport sink   (input valid, req_type, index, value, output ready);
endinterface

interface isss_rsp_if
  import isss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic                     status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

>>> hw/rtl/isss_store.sv
module isss_store
  import isss_pkg::*;
#(
  parameter int SIZE = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  store_cmd_t                 cmd,
  input  logic [$clog2(SIZE)-1:0]    rd_addr,
  input  logic [$clog2(SIZE)-1:0]    wr_addr,
  output logic signed [DATA_W-1:0]   rd_data
);

  logic [DATA_W-1:0] ram [SIZE];
  logic [SIZE-1:0]   written;
  logic [DATA_W-1:0] ram_q;
  logic              written_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ram[wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      ram_q     <= ram[rd_addr];
      written_q <= written[rd_addr];
    end
  end

  // An entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = written_q ? $signed(ram_q) : '0;

endmodule

>>> hw/rtl/indexed_store_selection_sort.sv
// Channel  Dir  Payload                         Transfer when
// -------  ---  ------------------------------  ------------------------
// req      in   req_type[1:0] index[3:0]        req.valid && req.ready
//               value[31:0] signed
// rsp      out  read_data[31:0] signed status   rsp.valid && rsp.ready
//
// Write, type-3 and out-of-range read requests load the result from idle; an
// in-range read registers the memory word and loads it from the read-return
// state. A sort holds the block for one memory read per scanned entry and two
// swap writes per position. The single write port of the store splits each
// swap into those two writes.
// Reset (rst, synchronous) empties the output register, returns to idle and
// clears the per-entry written flags so every element reads as zero.
// req.ready is high in idle while the output register is empty or drains in
// the same cycle; a stalled rsp holds its result and blocks further requests.
module indexed_store_selection_sort
  import isss_pkg::*;
#(
  parameter int SIZE = 8
) (
  input  logic       clk,
  input  logic       rst,
  isss_req_if.sink   req,
  isss_rsp_if.source rsp
);

  localparam int AW = $clog2(SIZE);
  localparam logic [AW-1:0] LAST      = AW'(SIZE - 1);
  localparam logic [AW-1:0] LAST_POS  = AW'(SIZE - 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDRET = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_SWAP1 = 3'd3;
  localparam logic [2:0] ST_SWAP2 = 3'd4;

  logic [2:0]               state;
  logic [AW-1:0]            pos;        // position being filled
  logic [AW-1:0]            rd_ptr;     // next scan address to read
  logic                     scan_issue; // scan reads still to issue
  logic                     rd_vld;     // read data returns this cycle
  logic [AW-1:0]            rd_idx;     // address of returning data
  logic signed [DATA_W-1:0] best_val;
  logic [AW-1:0]            best_idx;
  logic signed [DATA_W-1:0] held;       // original word at pos
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_status;

  store_cmd_t               cmd;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic                     req_xfer;
  logic                     in_range;
  logic [AW-1:0]            req_addr;

  isss_store #(.SIZE(SIZE)) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd_data (rd_data)
  );

  // Accept only in idle, and only when the output register will be free
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign req_xfer  = req.valid && req.ready;
  assign in_range  = {1'b0, req.index} < (IDX_W + 1)'(SIZE);
  assign req_addr  = req.index[AW-1:0];

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

  // Drive the store: request accesses in idle, scan reads and swap writes
  always_comb begin
    cmd.rd_en   = 1'b0;
    cmd.wr_en   = 1'b0;
    cmd.wr_data = req.value;
    rd_addr     = req_addr;
    wr_addr     = req_addr;
    case (state)
      ST_IDLE: begin
        if (req_xfer && in_range) begin
          cmd.wr_en = (req.req_type == REQ_WRITE);
          cmd.rd_en = (req.req_type == REQ_READ);
        end
      end
      ST_SCAN: begin
        cmd.rd_en = scan_issue;
        rd_addr   = rd_ptr;
      end
      ST_SWAP1: begin
        cmd.wr_en   = 1'b1;
        wr_addr     = pos;
        cmd.wr_data = best_val;
      end
      ST_SWAP2: begin
        cmd.wr_en   = 1'b1;
        wr_addr     = best_idx;
        cmd.wr_data = held;
      end
      default: begin
        cmd.rd_en = 1'b0;
      end
    endcase
  end

  // Payload registers of the sort datapath
  always_ff @(posedge clk) begin
    rd_idx <= rd_ptr;
    if (state == ST_IDLE) begin
      pos    <= '0;
      rd_ptr <= '0;
    end
    if (state == ST_SCAN) begin
      if (scan_issue && rd_ptr != LAST) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (rd_vld) begin
        if (rd_idx == pos) begin
          // first word of the pass: seed the maximum, hold the original
          best_val <= rd_data;
          best_idx <= pos;
          held     <= rd_data;
        end else if (rd_data > best_val) begin
          // strict compare keeps the first maximum
          best_val <= rd_data;
          best_idx <= rd_idx;
        end
      end
    end
    if (state == ST_SWAP2 && pos != LAST_POS) begin
      pos    <= pos + 1'b1;
      rd_ptr <= pos + 1'b1;
    end
  end

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_issue <= 1'b0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN) && scan_issue;
      // drop the result once the sink takes it; a new result may load below
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            case (req.req_type)
              REQ_WRITE: begin
                out_valid  <= 1'b1;
                out_data   <= '0;
                out_status <= in_range ? STATUS_OK : STATUS_RANGE;
              end
              REQ_READ: begin
                if (in_range) begin
                  state <= ST_RDRET;
                end else begin
                  out_valid  <= 1'b1;
                  out_data   <= '0;
                  out_status <= STATUS_RANGE;
                end
              end
              REQ_SORT: begin
                scan_issue <= 1'b1;
                state      <= ST_SCAN;
              end
              default: begin
                out_valid  <= 1'b1;
                out_data   <= '0;
                out_status <= STATUS_OK;
              end
            endcase
          end
        end
        ST_RDRET: begin
          out_valid  <= 1'b1;
          out_data   <= rd_data;
          out_status <= STATUS_OK;
          state      <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_issue && rd_ptr == LAST) begin
            scan_issue <= 1'b0;
          end
          if (rd_vld && rd_idx == LAST) begin
            state <= ST_SWAP1;
          end
        end
        ST_SWAP1: begin
          state <= ST_SWAP2;
        end
        ST_SWAP2: begin
          if (pos == LAST_POS) begin
            out_valid  <= 1'b1;
            out_data   <= '0;
            out_status <= STATUS_OK;
            state      <= ST_IDLE;
          end else begin
            scan_issue <= 1'b1;
            state      <= ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
